[src/dmpwm_pkg.sv]
// shared types and constants for the dual motor pwm driver
// no dependencies; imported by every module of the block
package dmpwm_pkg;

    localparam int MOTOR_COUNT = 2;
    localparam int CNT_W       = 16;
    localparam int DUTY_W      = 8;
    localparam int DIR_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CNT_W-1:0]  PWM_TOP_RST     = 16'd100;
    localparam logic [DUTY_W-1:0] SPEED_LIMIT_RST = 8'd100;
    localparam logic [CNT_W-1:0]  DEAD_TICKS_RST  = 16'd32000;

    // bridge direction bits
    localparam logic [DIR_W-1:0] DIR_L_REV = 4'h1;
    localparam logic [DIR_W-1:0] DIR_L_FWD = 4'h2;
    localparam logic [DIR_W-1:0] DIR_R_FWD = 4'h4;
    localparam logic [DIR_W-1:0] DIR_R_REV = 4'h8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_TOP     = 2'd0,
        CFG_SPEED_LIMIT = 2'd1,
        CFG_DEAD_TICKS  = 2'd2
    } t_cfg_idx;

    // lane update controls from the shared controller
    typedef struct packed {
        logic step;
        logic pend_load;
        logic buf_clear;
        logic buf_mag;
        logic buf_pend;
        logic latch;
    } t_lane_ctl;

    typedef struct packed {
        logic             pwm_left;
        logic             pwm_right;
        logic [DIR_W-1:0] bridge_dir;
        logic             waiting;
    } t_result;

endpackage

[src/dmpwm_if.sv]
// handshake channels of the dual motor pwm driver
// no dependencies on other files
interface dmpwm_cmd_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic signed [7:0] left_speed;
    logic signed [7:0] right_speed;

    modport source (output valid, output action, output left_speed, output right_speed,
                    input ready);
    modport sink (input valid, input action, input left_speed, input right_speed,
                  output ready);
endinterface

interface dmpwm_res_if;
    logic       valid;
    logic       ready;
    logic       pwm_left;
    logic       pwm_right;
    logic [3:0] bridge_dir;
    logic       waiting;

    modport source (output valid, output pwm_left, output pwm_right, output bridge_dir,
                    output waiting, input ready);
    modport sink (input valid, input pwm_left, input pwm_right, input bridge_dir,
                  input waiting, output ready);
endinterface

[src/dual_motor_pwm_with_dead_time.sv]
// top level of the dual motor pwm driver with dead time
// each accepted beat's result goes into the result register, or into the skid entry
// while o_res stalls; one beat per cycle, ticks and commands alike, while i_cmd is ready;
// the counter, dead time and lane duty updates all settle in the cycle of the beat
// a two-entry output stage (result register plus skid) keeps i_cmd ready while one
// result waits; reset is synchronous active low and restores state and valid flags at once
module dual_motor_pwm_with_dead_time (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    dmpwm_cmd_if.sink                           i_cmd,
    dmpwm_res_if.source                         o_res,
    input  logic                                i_cfg_we,
    input  logic [dmpwm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dmpwm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import dmpwm_pkg::*;

    // configuration registers
    logic [CNT_W-1:0]  r_pwm_top;
    logic [DUTY_W-1:0] r_speed_limit;
    logic [CNT_W-1:0]  r_dead_ticks;

    // shared controller to lanes
    t_lane_ctl         lane_ctl;
    logic [CNT_W-1:0]  next_count;
    logic [DIR_W-1:0]  next_dir;
    logic              next_waiting;
    logic [MOTOR_COUNT-1:0] lane_pwm;

    // output stage
    t_result r_out, r_skid, new_res;
    logic    r_out_valid, r_skid_valid;
    logic    in_ready, accept, out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_top     <= PWM_TOP_RST;
            r_speed_limit <= SPEED_LIMIT_RST;
            r_dead_ticks  <= DEAD_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PWM_TOP:     r_pwm_top     <= i_cfg_data;
                CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data[DUTY_W-1:0];
                CFG_DEAD_TICKS:  r_dead_ticks  <= i_cfg_data;
                default: ;  // unmapped index is ignored
            endcase
        end
    end

    assign in_ready    = ~r_skid_valid;
    assign accept      = i_cmd.valid & in_ready;
    assign i_cmd.ready = in_ready;

    dmpwm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (accept),
        .i_action     (i_cmd.action),
        .i_left_neg   (i_cmd.left_speed[7]),
        .i_right_neg  (i_cmd.right_speed[7]),
        .i_pwm_top    (r_pwm_top),
        .i_dead_ticks (r_dead_ticks),
        .o_ctl        (lane_ctl),
        .o_count      (next_count),
        .o_dir        (next_dir),
        .o_waiting    (next_waiting)
    );

    // one lane per motor; only the first two take commanded speeds
    for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_lane
        logic signed [7:0] lane_speed;
        if (m == 0) begin : g_left
            assign lane_speed = i_cmd.left_speed;
        end else if (m == 1) begin : g_right
            assign lane_speed = i_cmd.right_speed;
        end else begin : g_idle
            assign lane_speed = '0;
        end

        dmpwm_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (lane_ctl),
            .i_speed       (lane_speed),
            .i_speed_limit (r_speed_limit),
            .i_count       (next_count),
            .o_pwm         (lane_pwm[m])
        );
    end

    // merge lane levels with the shared direction and dead time status
    always_comb begin
        new_res.pwm_left   = lane_pwm[0];
        new_res.pwm_right  = (MOTOR_COUNT > 1) ? lane_pwm[MOTOR_COUNT > 1 ? 1 : 0] : 1'b0;
        new_res.bridge_dir = next_dir;
        new_res.waiting    = next_waiting;
    end

    // result register with skid entry behind it
    assign out_free = ~r_out_valid | o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= new_res;
            end
        end else if (accept) begin
            r_skid <= new_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.pwm_left   = r_out.pwm_left;
    assign o_res.pwm_right  = r_out.pwm_right;
    assign o_res.bridge_dir = r_out.bridge_dir;
    assign o_res.waiting    = r_out.waiting;

endmodule

[src/dmpwm_lane.sv]
// one motor lane: magnitude and clip, pending/buffered/active duty, pwm compare
// depends on dmpwm_pkg
module dmpwm_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dmpwm_pkg::t_lane_ctl             i_ctl,
    input  logic signed [7:0]                i_speed,
    input  logic [dmpwm_pkg::DUTY_W-1:0]     i_speed_limit,
    input  logic [dmpwm_pkg::CNT_W-1:0]      i_count,
    output logic                             o_pwm
);
    import dmpwm_pkg::*;

    logic [DUTY_W-1:0] r_pend, r_buf, r_act;
    logic [DUTY_W-1:0] n_pend, n_buf, n_act;
    logic [DUTY_W:0]   mag_raw;
    logic [DUTY_W-1:0] mag;

    // magnitude of a signed byte, -128 gives 128, then clipped to the speed limit
    always_comb begin
        if (i_speed[7]) begin
            mag_raw = 9'd256 - {1'b0, i_speed};
        end else begin
            mag_raw = {1'b0, i_speed};
        end
        if (mag_raw > {1'b0, i_speed_limit}) begin
            mag = i_speed_limit;
        end else begin
            mag = mag_raw[DUTY_W-1:0];
        end
    end

    always_comb begin
        n_pend = i_ctl.pend_load ? mag : r_pend;
        priority if (i_ctl.buf_clear) begin
            n_buf = '0;
        end else if (i_ctl.buf_mag) begin
            n_buf = mag;
        end else if (i_ctl.buf_pend) begin
            n_buf = r_pend;
        end else begin
            n_buf = r_buf;
        end
        n_act = i_ctl.latch ? n_buf : r_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_buf  <= '0;
            r_act  <= '0;
        end else if (i_ctl.step) begin
            r_pend <= n_pend;
            r_buf  <= n_buf;
            r_act  <= n_act;
        end
    end

    assign o_pwm = i_count < {{(CNT_W-DUTY_W){1'b0}}, n_act};

endmodule

[src/dmpwm_ctrl.sv]
// shared controller: up/down counter, dead time and bridge direction
// depends on dmpwm_pkg
module dmpwm_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic                            i_action,
    input  logic                            i_left_neg,
    input  logic                            i_right_neg,
    input  logic [dmpwm_pkg::CNT_W-1:0]     i_pwm_top,
    input  logic [dmpwm_pkg::CNT_W-1:0]     i_dead_ticks,
    output dmpwm_pkg::t_lane_ctl            o_ctl,
    output logic [dmpwm_pkg::CNT_W-1:0]     o_count,
    output logic [dmpwm_pkg::DIR_W-1:0]     o_dir,
    output logic                            o_waiting
);
    import dmpwm_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_down, n_down;
    logic [DIR_W-1:0] r_adir, n_adir;
    logic [DIR_W-1:0] r_pdir, n_pdir;
    logic [CNT_W-1:0] r_dcount, n_dcount;
    logic             r_dead, n_dead;
    logic [DIR_W-1:0] cmd_dir;
    logic [CNT_W-1:0] dec_dead;
    logic [CNT_W-1:0] cnt_step;
    t_lane_ctl        ctl;

    assign cmd_dir  = (i_left_neg ? DIR_L_REV : DIR_L_FWD) | (i_right_neg ? DIR_R_REV : DIR_R_FWD);
    assign dec_dead = r_dcount - 1'b1;

    always_comb begin
        n_count  = r_count;
        n_down   = r_down;
        n_adir   = r_adir;
        n_pdir   = r_pdir;
        n_dcount = r_dcount;
        n_dead   = r_dead;
        cnt_step = r_count;
        ctl      = '0;
        ctl.step = i_step;
        if (i_step) begin
            if (i_action) begin
                if (r_dead) begin
                    // replace pending command, dead time keeps running
                    n_pdir        = cmd_dir;
                    ctl.pend_load = 1'b1;
                end else if (cmd_dir != r_adir && i_dead_ticks != '0) begin
                    ctl.buf_clear = 1'b1;
                    ctl.pend_load = 1'b1;
                    n_pdir        = cmd_dir;
                    n_dcount      = i_dead_ticks;
                    n_dead        = 1'b1;
                end else begin
                    n_adir      = cmd_dir;
                    ctl.buf_mag = 1'b1;
                end
            end else begin
                if (r_dead) begin
                    n_dcount = dec_dead;
                    if (dec_dead == '0) begin
                        n_dead       = 1'b0;
                        n_adir       = r_pdir;
                        ctl.buf_pend = 1'b1;
                    end
                end
                if (!r_down) begin
                    cnt_step = (r_count < i_pwm_top) ? r_count + 1'b1 : r_count;
                    if (cnt_step >= i_pwm_top) begin
                        n_count = i_pwm_top;
                        n_down  = 1'b1;
                    end else begin
                        n_count = cnt_step;
                    end
                end else begin
                    cnt_step = (r_count != '0) ? r_count - 1'b1 : r_count;
                    n_count  = cnt_step;
                    if (cnt_step == '0) begin
                        n_down = 1'b0;
                    end
                end
                ctl.latch = (n_count == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_down   <= 1'b0;
            r_adir   <= '0;
            r_pdir   <= '0;
            r_dcount <= '0;
            r_dead   <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_down   <= n_down;
            r_adir   <= n_adir;
            r_pdir   <= n_pdir;
            r_dcount <= n_dcount;
            r_dead   <= n_dead;
        end
    end

    assign o_ctl     = ctl;
    assign o_count   = n_count;
    assign o_dir     = n_adir;
    assign o_waiting = n_dead;

endmodule

[test/tb.sv]
// self-checking testbench for the dual motor pwm driver with dead time
// drives command and tick beats, writes the registers between phases and scores every
// result beat against a beat-level predictor; needs dmpwm_pkg, dmpwm_if and the rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmpwm_pkg::*;

    localparam int RANDOM_ITEMS  = 1800;
    localparam int SETTLE_CYCLES = 4;       // result register plus skid, with margin
    localparam int CYCLE_LIMIT   = 600000;  // ~1830 beats at worst gap and stall, several times over
    localparam int REPORT_MAX    = 10;
    localparam int PLAN_ROWS     = 33;

    localparam logic [DIR_W-1:0] DIR_NONE = '0;

    typedef enum bit {ACT_TICK = 1'b0, ACT_CMD = 1'b1} t_action;
    typedef enum bit {ROW_BEAT = 1'b0, ROW_CFG = 1'b1} t_row_kind;

    // one line of the directed plan: either a register write or a beat
    typedef struct packed {
        t_row_kind             kind;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] value;
        t_action               act;
        logic [7:0]            left;
        logic [7:0]            right;
        bit                    typed;
        t_result               want;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  sink_ready = 1'b0;

    dmpwm_cmd_if cmd_ch ();
    dmpwm_res_if res_ch ();

    assign res_ch.ready = sink_ready;

    dual_motor_pwm_with_dead_time u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor: own copy of the registers and of the bridge state
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  top_reg;
    logic [DUTY_W-1:0] limit_reg;
    logic [CNT_W-1:0]  dead_reg;

    logic [CNT_W-1:0]  ramp;                      // up/down pwm counter
    bit                ramp_down;
    logic [DUTY_W-1:0] duty_live   [MOTOR_COUNT]; // compared against the counter
    logic [DUTY_W-1:0] duty_shadow [MOTOR_COUNT]; // latched into duty_live at the bottom
    logic [DUTY_W-1:0] duty_pend   [MOTOR_COUNT]; // held back during the dead time
    logic [DIR_W-1:0]  dir_live;
    logic [DIR_W-1:0]  dir_pend;
    logic [CNT_W-1:0]  dead_left;
    bit                in_dead;

    t_result levels_due [$];   // predicted output levels, oldest first

    // stimulus shaping, shared with the sink process
    bit gaps_on;
    bit stalls_on;
    int stall_left = 0;

    int beats_sent;
    int cmds_sent;
    int ticks_sent;
    int results_seen;
    int reg_writes;
    int mismatches;
    int cycle_cnt = 0;

    // speed byte to duty magnitude; -128 gives 128, then the limit applies
    function automatic logic [DUTY_W-1:0] clip_mag(logic [7:0] speed);
        logic [8:0] mag;
        mag = speed[7] ? (9'd256 - {1'b0, speed}) : {1'b0, speed};
        if (mag > {1'b0, limit_reg})
            mag = {1'b0, limit_reg};
        return mag[DUTY_W-1:0];
    endfunction

    task automatic advance_bridge(input t_action act, input logic [7:0] left,
                                  input logic [7:0] right, output t_result levels);
        logic [DUTY_W-1:0] mag [2];
        logic [DIR_W-1:0]  dir;
        int                m;
        if (act == ACT_CMD) begin
            mag[0] = clip_mag(left);
            mag[1] = clip_mag(right);
            // zero speed counts as forward
            dir = (left[7] ? DIR_L_REV : DIR_L_FWD) | (right[7] ? DIR_R_REV : DIR_R_FWD);
            if (in_dead) begin
                // a command inside the dead time only replaces what is pending
                dir_pend = dir;
                for (m = 0; m < MOTOR_COUNT && m < 2; m++)
                    duty_pend[m] = mag[m];
            end else if (dir != dir_live && dead_reg != '0) begin
                // direction change: drop the duties and start the dead time
                for (m = 0; m < MOTOR_COUNT; m++)
                    duty_shadow[m] = '0;
                dir_pend = dir;
                for (m = 0; m < MOTOR_COUNT && m < 2; m++)
                    duty_pend[m] = mag[m];
                dead_left = dead_reg;
                in_dead   = 1'b1;
            end else begin
                dir_live = dir;
                for (m = 0; m < MOTOR_COUNT && m < 2; m++)
                    duty_shadow[m] = mag[m];
            end
        end else begin
            if (in_dead) begin
                dead_left = dead_left - 16'd1;
                if (dead_left == '0) begin
                    in_dead  = 1'b0;
                    dir_live = dir_pend;
                    for (m = 0; m < MOTOR_COUNT; m++)
                        duty_shadow[m] = duty_pend[m];
                end
            end
            // a counter above a lowered top jumps to it when rising, keeps falling otherwise
            if (!ramp_down) begin
                if (ramp < top_reg)
                    ramp = ramp + 16'd1;
                if (ramp >= top_reg) begin
                    ramp      = top_reg;
                    ramp_down = 1'b1;
                end
            end else begin
                if (ramp != '0)
                    ramp = ramp - 16'd1;
                if (ramp == '0)
                    ramp_down = 1'b0;
            end
            if (ramp == '0) begin
                for (m = 0; m < MOTOR_COUNT; m++)
                    duty_live[m] = duty_shadow[m];
            end
        end
        levels.pwm_left   = ramp < 16'(duty_live[0]);
        levels.pwm_right  = (MOTOR_COUNT > 1) && (ramp < 16'(duty_live[MOTOR_COUNT > 1 ? 1 : 0]));
        levels.bridge_dir = dir_live;
        levels.waiting    = in_dead;
    endtask

    // ------------------------------------------------------------------
    // random shaping helpers
    // ------------------------------------------------------------------

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // speed byte leaning on the extremes; the sign can be pinned
    function automatic logic [7:0] pick_speed(bit pin_sign, bit want_neg);
        logic [7:0] speed;
        case ($urandom_range(0, 9))
            0: speed = 8'h80;   // -128
            1: speed = 8'h7F;   // 127
            2: speed = 8'h00;
            3: speed = 8'hFF;   // -1
            4: speed = 8'h01;
            default: speed = 8'($urandom_range(0, 255));
        endcase
        if (pin_sign)
            speed = want_neg ? (speed | 8'h80) : (speed & 8'h7F);
        return speed;
    endfunction

    function automatic logic [CNT_W-1:0] pick_top();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'd1;
        else if (r < 40)
            return 16'($urandom_range(2, 8));
        else if (r < 85)
            return 16'($urandom_range(9, 60));
        else if (r < 95)
            return 16'd100;
        else
            return 16'hFFFF;
    endfunction

    function automatic logic [DUTY_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'd0;
        else if (r < 25)
            return 8'd128;
        else if (r < 30)
            return 8'($urandom_range(129, 255));   // beyond any magnitude
        else
            return 8'($urandom_range(1, 127));
    endfunction

    function automatic logic [CNT_W-1:0] pick_dead();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 16'd0;
        else if (r < 30)
            return 16'd1;
        else if (r < 85)
            return 16'($urandom_range(2, 12));
        else if (r < 95)
            return 16'($urandom_range(13, 64));
        else
            return 16'hFFFF;
    endfunction

    // ------------------------------------------------------------------
    // directed plan rows
    // ------------------------------------------------------------------
    function automatic t_plan_row beat_row(t_action act, logic [7:0] left, logic [7:0] right);
        t_plan_row row;
        row       = '0;
        row.kind  = ROW_BEAT;
        row.act   = act;
        row.left  = left;
        row.right = right;
        return row;
    endfunction

    function automatic t_plan_row checked_row(t_action act, logic [7:0] left,
                                              logic [7:0] right, t_result want);
        t_plan_row row;
        row       = beat_row(act, left, right);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic t_plan_row cfg_row(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        t_plan_row row;
        row       = '0;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.value = value;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one command or tick beat; the prediction is taken when the beat is accepted
    task automatic send_beat(input t_action act, input logic [7:0] left, input logic [7:0] right,
                             input bit typed, input t_result want);
        int      gap;
        t_result levels;
        gap = gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.action      <= act;
        cmd_ch.left_speed  <= left;
        cmd_ch.right_speed <= right;
        @(posedge i_clk);
        while (!cmd_ch.ready)
            @(posedge i_clk);
        advance_bridge(act, left, right, levels);
        levels_due.push_back(typed ? want : levels);
        beats_sent++;
        if (act == ACT_CMD)
            cmds_sent++;
        else
            ticks_sent++;
    endtask

    // register write once the block has drained
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cmd_ch.valid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PWM_TOP:     top_reg   = value;
            CFG_SPEED_LIMIT: limit_reg = value[DUTY_W-1:0];
            CFG_DEAD_TICKS:  dead_reg  = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic note_fail(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display({"%s: expected left=%b right=%b dir=%h wait=%b, ",
                      "got left=%b right=%b dir=%h wait=%b"},
                     what, want.pwm_left, want.pwm_right, want.bridge_dir, want.waiting,
                     got.pwm_left, got.pwm_right, got.bridge_dir, got.waiting);
    endtask

    // ------------------------------------------------------------------
    // result side: random back-pressure and scoring
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!stalls_on) begin
            sink_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            sink_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
            stall_left <= pick_gap();
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        got.pwm_left   = res_ch.pwm_left;
        got.pwm_right  = res_ch.pwm_right;
        got.bridge_dir = res_ch.bridge_dir;
        got.waiting    = res_ch.waiting;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            results_seen++;
            if (levels_due.size() == 0) begin
                note_fail("result beat with nothing pending", '0, got);
            end else begin
                want = levels_due.pop_front();
                // field by field, x counts as wrong
                if (got.pwm_left !== want.pwm_left || got.pwm_right !== want.pwm_right ||
                    got.bridge_dir !== want.bridge_dir || got.waiting !== want.waiting)
                    note_fail($sformatf("mismatch on result %0d", results_seen), want, got);
            end
        end
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_cnt, levels_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        t_plan_row  plan [PLAN_ROWS];
        int         i;
        int         m;
        int         phase_len;
        int         cmd_pct;
        int         phases;
        int         random_beats;
        bit         hold_dir;
        bit         pin;
        logic [7:0] left;
        logic [7:0] right;

        // every input known from time zero, reset held low
        i_rst_n            <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.action      <= ACT_TICK;
        cmd_ch.left_speed  <= '0;
        cmd_ch.right_speed <= '0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_PWM_TOP;
        cfg_data           <= '0;

        // predictor starts from the reset state
        top_reg   = PWM_TOP_RST;
        limit_reg = SPEED_LIMIT_RST;
        dead_reg  = DEAD_TICKS_RST;
        ramp      = '0;
        ramp_down = 1'b0;
        for (m = 0; m < MOTOR_COUNT; m++) begin
            duty_live[m]   = '0;
            duty_shadow[m] = '0;
            duty_pend[m]   = '0;
        end
        dir_live     = DIR_NONE;
        dir_pend     = DIR_NONE;
        dead_left    = '0;
        in_dead      = 1'b0;
        beats_sent   = 0;
        cmds_sent    = 0;
        ticks_sent   = 0;
        results_seen = 0;
        reg_writes   = 0;
        mismatches   = 0;
        phases       = 0;
        random_beats = 0;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;

        // directed part: reset levels, first command, dead time, register extremes
        plan = '{
            // fresh out of reset: counter climbing, duties zero, no direction
            checked_row(ACT_TICK, 8'h00, 8'h00, t_result'{1'b0, 1'b0, DIR_NONE, 1'b0}),
            checked_row(ACT_TICK, 8'h5A, 8'hA5, t_result'{1'b0, 1'b0, DIR_NONE, 1'b0}),
            cfg_row(CFG_DEAD_TICKS, 16'd2),
            // with a nonzero dead time the first command starts one; zero speed is forward
            checked_row(ACT_CMD, 8'h00, 8'h00, t_result'{1'b0, 1'b0, DIR_NONE, 1'b1}),
            // command inside the dead time replaces the pending one
            checked_row(ACT_CMD, 8'h80, 8'h7F, t_result'{1'b0, 1'b0, DIR_NONE, 1'b1}),
            checked_row(ACT_TICK, 8'h00, 8'h00, t_result'{1'b0, 1'b0, DIR_NONE, 1'b1}),
            // dead time over: pending direction applied, duties wait for the bottom
            checked_row(ACT_TICK, 8'h00, 8'h00,
                        t_result'{1'b0, 1'b0, DIR_L_REV | DIR_R_FWD, 1'b0}),
            // top lowered under a rising counter: jump and turn, then latch at zero
            cfg_row(CFG_PWM_TOP, 16'd1),
            beat_row(ACT_TICK, 8'h00, 8'h00),
            beat_row(ACT_TICK, 8'h00, 8'h00),
            // full magnitude of -128 passes at the top limit
            cfg_row(CFG_SPEED_LIMIT, 16'd128),
            beat_row(ACT_CMD, 8'h80, 8'h80),
            beat_row(ACT_TICK, 8'hFF, 8'h00),
            beat_row(ACT_TICK, 8'h00, 8'hFF),
            beat_row(ACT_TICK, 8'h00, 8'h00),
            // zero dead time: direction change applied at once
            cfg_row(CFG_DEAD_TICKS, 16'd0),
            beat_row(ACT_CMD, 8'h7F, 8'hFF),      // 127, -1
            beat_row(ACT_TICK, 8'h00, 8'h00),
            beat_row(ACT_TICK, 8'h00, 8'h00),
            cfg_row(CFG_SPEED_LIMIT, 16'd0),
            beat_row(ACT_CMD, 8'h32, 8'hCE),      // 50, -50 clipped to nothing
            beat_row(ACT_TICK, 8'h00, 8'h00),
            beat_row(ACT_TICK, 8'h00, 8'h00),
            // limit above any magnitude
            cfg_row(CFG_SPEED_LIMIT, 16'd255),
            beat_row(ACT_CMD, 8'h80, 8'h7F),
            beat_row(ACT_TICK, 8'h00, 8'h00),
            beat_row(ACT_TICK, 8'h00, 8'h00),
            cfg_row(CFG_PWM_TOP, 16'hFFFF),
            beat_row(ACT_TICK, 8'h00, 8'h00),
            beat_row(ACT_TICK, 8'h00, 8'h00),
            // longest dead time, only same-direction commands from here
            cfg_row(CFG_DEAD_TICKS, 16'hFFFF),
            beat_row(ACT_CMD, 8'hFD, 8'h03),      // -3, 3
            beat_row(ACT_TICK, 8'h00, 8'h00)
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < PLAN_ROWS; i++) begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].idx, plan[i].value);
            else
                send_beat(plan[i].act, plan[i].left, plan[i].right, plan[i].typed, plan[i].want);
        end

        // random phases: new settings, then a mostly-tick stream with commands mixed in
        while (random_beats < RANDOM_ITEMS) begin
            phases++;
            if ($urandom_range(0, 1) != 0)
                write_reg(CFG_PWM_TOP, pick_top());
            if ($urandom_range(0, 1) != 0)
                write_reg(CFG_SPEED_LIMIT, {8'd0, pick_limit()});
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_DEAD_TICKS, pick_dead());
            // with a long dead time keep the applied direction so the run does not stall
            hold_dir  = dead_reg > 16'd64;
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            phase_len = $urandom_range(40, 120);
            cmd_pct   = $urandom_range(5, 30);
            repeat (phase_len) begin
                if ($urandom_range(0, 99) < cmd_pct) begin
                    pin   = hold_dir && !in_dead;
                    left  = pick_speed(pin, (dir_live & DIR_L_REV) != '0);
                    right = pick_speed(pin, (dir_live & DIR_R_REV) != '0);
                    send_beat(ACT_CMD, left, right, 1'b0, '0);
                end else begin
                    // speed fields of a tick carry noise
                    send_beat(ACT_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              1'b0, '0);
                end
                random_beats++;
            end
        end

        // drain, then let the output stage settle
        cmd_ch.valid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);

        $display("covered %0d beats (%0d commands, %0d ticks) over %0d random settings",
                 beats_sent, cmds_sent, ticks_sent, phases);
        $display("%0d result beats scored, %0d register writes, %0d mismatches",
                 results_seen, reg_writes, mismatches);
        if (mismatches == 0 && levels_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
src/dmpwm_pkg.sv
src/dmpwm_if.sv
src/dmpwm_lane.sv
src/dmpwm_ctrl.sv
src/dual_motor_pwm_with_dead_time.sv
test/tb.sv
